[rtl/core/binary_cross_entropy_loss_core_defines.svh]
`ifndef BINARY_CROSS_ENTROPY_LOSS_CORE_DEFINES_SVH
`define BINARY_CROSS_ENTROPY_LOSS_CORE_DEFINES_SVH

// same-cycle implication on clk_i, off while rst_ni is low
`define BCE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk_i, off while rst_ni is low
`define BCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/bce_pkg.sv]
`default_nettype none

package bce_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int LN_TABLE_BITS = 8;
  localparam int ACC_WIDTH     = 48;

  localparam int IN_W        = FRAC_BITS + 1;
  localparam int IN_TDATA_W  = ((2 * IN_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((ACC_WIDTH + 7) / 8) * 8;

  // normalized fraction is 31 bits: table index on top, remainder below
  localparam int FRAC_W    = 31;
  localparam int REM_BITS  = FRAC_W - LN_TABLE_BITS;
  localparam int TAB_W     = 31;
  localparam int TAB_DEPTH = (1 << LN_TABLE_BITS) + 1;
  localparam int TAB_IDX_W = $clog2(TAB_DEPTH);
  localparam int SH_W      = FRAC_W + FRAC_BITS;
  localparam int SHAMT_W   = $clog2(FRAC_W + 1);
  localparam int P_W       = $clog2(FRAC_BITS);
  localparam int K_W       = $clog2(FRAC_BITS + 1);

  // shared multiplier
  localparam int MUL_A_W = 31;
  localparam int MUL_B_W = 28;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int KL_W    = K_W + MUL_B_W;

  // -ln in Q.FRAC_BITS stays below 2^(FRAC_BITS+5)
  localparam int NL_W   = FRAC_BITS + 5;
  localparam int SUM_W  = 2 * FRAC_BITS + 6;
  localparam int TERM_W = FRAC_BITS + 6;

  localparam logic [IN_W-1:0]      ONE     = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [MUL_B_W-1:0]   LN2_Q28 = MUL_B_W'(186065279);
  localparam logic [ACC_WIDTH-1:0] ACC_MAX = '1;
  localparam logic [TAB_W-1:0]     Q30_ONE = TAB_W'(1) << 30;

  localparam logic [63:0] NL_EPS_Q32   = 64'd69226693695;
  localparam logic [63:0] NL_NEAR1_Q32 = 64'd430;
  localparam logic [NL_W-1:0] NL_EPS =
    NL_W'((NL_EPS_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
  localparam logic [NL_W-1:0] NL_NEAR1 =
    NL_W'((NL_NEAR1_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));

  localparam logic [63:0]    RND_NL  = 64'd1 << (57 - FRAC_BITS);
  localparam logic [SUM_W-1:0] RND_TERM = SUM_W'(1) << (FRAC_BITS - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_NORM,
    S_TAB0,
    S_TAB1,
    S_MULR,
    S_INTERP,
    S_MULK,
    S_MULL,
    S_NLOG,
    S_MULC,
    S_MULNC,
    S_ACCUM,
    S_EMIT
  } state_e;

  // log2(1 + i/2^LN_TABLE_BITS) in Q30 by repeated squaring, truncated
  function automatic logic [TAB_W-1:0] log2_point(int unsigned i);
    logic [63:0]      y;
    logic [TAB_W-1:0] r;
    r = '0;
    y = 64'(Q30_ONE) + (64'(i) << (30 - LN_TABLE_BITS));
    for (int k = 1; k <= 30; k++) begin
      y = (y * y) >> 30;
      if (y >= (64'(Q30_ONE) << 1)) begin
        y = y >> 1;
        r[30 - k] = 1'b1;
      end
    end
    if (i >= (1 << LN_TABLE_BITS)) begin
      r = Q30_ONE;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/bce_mul.sv]
`default_nettype none

module bce_mul (
  input  logic                         clk_i,
  input  logic [bce_pkg::MUL_A_W-1:0]  a_i,
  input  logic [bce_pkg::MUL_B_W-1:0]  b_i,
  output logic [bce_pkg::MUL_P_W-1:0]  p_o
);
  import bce_pkg::*;

  logic [MUL_P_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

[rtl/core/binary_cross_entropy_loss_core.sv]
// a beat is taken only in idle; s_axis_tready_o stays low until it has been accumulated,
// and a prediction of zero or one skips both logarithms; the single shared multiplier and
// one table read per cycle serialize the work, each logarithm runs eight sequencer steps
// after a last beat the emit state loads the result and sets m_axis_tvalid_o, and it waits
// there while the previous result is still held on the output
// reset (rst_ni low, asynchronous) clears the sum, the overflow flag and the output valid
`default_nettype none

`include "binary_cross_entropy_loss_core_defines.svh"

module binary_cross_entropy_loss_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // prediction, target, zero fill
  input  logic [bce_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  input  logic                              s_axis_tlast_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // loss
  output logic [bce_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  // saturated
  output logic                              m_axis_tuser_o
);
  import bce_pkg::*;

  state_e state_q, state_d;

  logic [IN_W-1:0]      x_in, c_in, x_cl, c_cl;
  logic                 s_accept, emit_go, special;

  logic [IN_W-1:0]      x_q, c_q;
  logic                 last_q, pass_q;
  logic [FRAC_BITS-1:0] arg_q;
  logic [LN_TABLE_BITS-1:0] idx_q;
  logic [REM_BITS-1:0]  rem_q;
  logic [K_W-1:0]       k_q;
  logic [TAB_W-1:0]     t0_q, diff_q, interp_q;
  logic [KL_W-1:0]      kl_q;
  logic [NL_W-1:0]      nlx_q, nl1x_q;
  logic [SUM_W-1:0]     sum_q;

  logic [ACC_WIDTH-1:0] loss_sum_q;
  logic                 ovf_q;
  logic [ACC_WIDTH-1:0] out_loss_q;
  logic                 out_sat_q, out_valid_q;

  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [MUL_P_W-1:0]   mul_p;

  logic [TAB_W-1:0]     l2_tab [TAB_DEPTH];
  logic [TAB_IDX_W-1:0] tab_idx;
  logic [TAB_W-1:0]     tab_rd;

  logic [P_W-1:0]       msb;
  logic [SH_W-1:0]      shl;
  logic [63:0]          nl_mix;
  logic [NL_W-1:0]      nl_val;
  logic [SUM_W-1:0]     term_full;
  logic [TERM_W-1:0]    term;
  logic [ACC_WIDTH:0]   acc_ext;
  logic                 acc_carry;

  // log2 table, built at elaboration
  for (genvar gi = 0; gi < TAB_DEPTH; gi++) begin : g_tab
    localparam logic [TAB_W-1:0] Entry = log2_point(gi);
    assign l2_tab[gi] = Entry;
  end

  assign tab_rd = l2_tab[tab_idx];

  bce_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign x_in     = s_axis_tdata_i[IN_W-1:0];
  assign c_in     = s_axis_tdata_i[2*IN_W-1:IN_W];
  assign x_cl     = x_in[FRAC_BITS] ? ONE : x_in;
  assign c_cl     = c_in[FRAC_BITS] ? ONE : c_in;
  assign special  = (x_in == '0) || x_in[FRAC_BITS];
  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;

  // normalizer: leading one position and left-aligned fraction below it
  always_comb begin
    msb = '0;
    for (int i = 0; i < FRAC_BITS; i++) begin
      if (arg_q[i]) begin
        msb = P_W'(i);
      end
    end
  end

  assign shl = SH_W'(arg_q) << (SHAMT_W'(FRAC_W) - SHAMT_W'(msb));

  // (k*ln2 << 30) - interp*ln2, rounded to FRAC_BITS fraction bits
  assign nl_mix = (64'(kl_q) << 30) - 64'(mul_p) + RND_NL;
  assign nl_val = NL_W'(nl_mix >> (58 - FRAC_BITS));

  assign term_full = sum_q + SUM_W'(mul_p) + RND_TERM;
  assign term      = TERM_W'(term_full >> FRAC_BITS);
  assign acc_ext   = {1'b0, loss_sum_q} + (ACC_WIDTH + 1)'(term);
  assign acc_carry = acc_ext[ACC_WIDTH];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          state_d = special ? S_MULC : S_NORM;
        end
      end
      S_NORM:   state_d = S_TAB0;
      S_TAB0:   state_d = S_TAB1;
      S_TAB1:   state_d = S_MULR;
      S_MULR:   state_d = S_INTERP;
      S_INTERP: state_d = S_MULK;
      S_MULK:   state_d = S_MULL;
      S_MULL:   state_d = S_NLOG;
      S_NLOG:   state_d = pass_q ? S_MULC : S_NORM;
      S_MULC:   state_d = S_MULNC;
      S_MULNC:  state_d = S_ACCUM;
      S_ACCUM:  state_d = last_q ? S_EMIT : S_IDLE;
      S_EMIT: begin
        if (emit_go) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    emit_go         = 1'b0;
    mul_a           = '0;
    mul_b           = '0;
    tab_idx         = '0;
    case (state_q)
      S_IDLE: s_axis_tready_o = 1'b1;
      S_TAB0: tab_idx = TAB_IDX_W'(idx_q);
      S_TAB1: tab_idx = TAB_IDX_W'(idx_q) + TAB_IDX_W'(1);
      S_MULR: begin
        mul_a = diff_q;
        mul_b = MUL_B_W'(rem_q);
      end
      S_MULK: begin
        mul_a = MUL_A_W'(k_q);
        mul_b = LN2_Q28;
      end
      S_MULL: begin
        mul_a = interp_q;
        mul_b = LN2_Q28;
      end
      S_MULC: begin
        mul_a = MUL_A_W'(nlx_q);
        mul_b = MUL_B_W'(c_q);
      end
      S_MULNC: begin
        mul_a = MUL_A_W'(nl1x_q);
        mul_b = MUL_B_W'(ONE - c_q);
      end
      S_EMIT: emit_go = !out_valid_q || m_axis_tready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      loss_sum_q  <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_ACCUM) begin
        loss_sum_q <= acc_carry ? ACC_MAX : acc_ext[ACC_WIDTH-1:0];
        ovf_q      <= ovf_q | acc_carry;
      end
      if (emit_go) begin
        loss_sum_q  <= '0;
        ovf_q       <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          x_q    <= x_cl;
          c_q    <= c_cl;
          last_q <= s_axis_tlast_i;
          arg_q  <= x_cl[FRAC_BITS-1:0];
          pass_q <= 1'b0;
          if (x_in[FRAC_BITS]) begin
            nlx_q  <= NL_NEAR1;
            nl1x_q <= NL_EPS;
          end else begin
            nlx_q  <= NL_EPS;
            nl1x_q <= NL_NEAR1;
          end
        end
      end
      S_NORM: begin
        idx_q <= shl[FRAC_W-1:REM_BITS];
        rem_q <= shl[REM_BITS-1:0];
        k_q   <= K_W'(FRAC_BITS) - K_W'(msb);
      end
      S_TAB0:   t0_q     <= tab_rd;
      S_TAB1:   diff_q   <= tab_rd - t0_q;
      S_INTERP: interp_q <= t0_q + TAB_W'(mul_p >> REM_BITS);
      S_MULL:   kl_q     <= KL_W'(mul_p);
      S_NLOG: begin
        if (pass_q) begin
          nl1x_q <= nl_val;
        end else begin
          nlx_q  <= nl_val;
          pass_q <= 1'b1;
          arg_q  <= FRAC_BITS'(ONE - x_q);
        end
      end
      S_MULNC: sum_q <= SUM_W'(mul_p);
      S_EMIT: begin
        if (emit_go) begin
          out_loss_q <= loss_sum_q;
          out_sat_q  <= ovf_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(out_loss_q);
  assign m_axis_tuser_o  = out_sat_q;

  `BCE_ASSERT_SAME(a_norm_arg_nonzero, state_q == S_NORM, arg_q != '0, "zero argument reached the normalizer")
  `BCE_ASSERT_NEXT(a_norm_exp_range, state_q == S_NORM, (k_q != '0) && (k_q <= K_W'(FRAC_BITS)), "exponent out of range after normalizing")
  `BCE_ASSERT_NEXT(a_sat_clamps, (state_q == S_ACCUM) && acc_carry, ovf_q && (loss_sum_q == ACC_MAX), "overflow did not clamp the sum")
  `BCE_ASSERT_NEXT(a_emit_clears, emit_go, m_axis_tvalid_o && (loss_sum_q == '0) && !ovf_q, "emit did not load the output and clear the sum")

endmodule

`default_nettype wire
